@@ rtl/cln_pkg.sv @@
`timescale 1ns / 1ps

package cln_pkg;

  localparam int unsigned FuncW   = 2;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned RowW    = 2;
  localparam int unsigned NibW    = 4;
  localparam int unsigned PulseW  = 16;
  localparam int unsigned HoldW   = 24;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned StepW   = 3;

  // request kinds
  typedef enum logic [FuncW-1:0] {
    FUNC_CMD    = 2'd0,
    FUNC_DATA   = 2'd1,
    FUNC_TEXT   = 2'd2,
    FUNC_CURSOR = 2'd3
  } func_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_PULSE_HOLD   = 2'd0,
    CFG_CMD_LEAD     = 2'd1
  } cfg_idx_e;

  localparam logic [PulseW-1:0] PULSE_HOLD_RST = 16'd10;
  localparam logic [HoldW-1:0]  CMD_LEAD_RST   = 24'd24000;

  localparam logic [ByteW-1:0] TEXT_REMAP_BASE = 8'd192;
  localparam logic [ByteW-1:0] CURSOR_SET_BIT  = 8'h80;

  localparam logic [ByteW-1:0] ROW_BASE [4] = '{8'h00, 8'h40, 8'h10, 8'h50};

  localparam logic [ByteW-1:0] CYR_ROM [64] = '{
    8'h41, 8'hA0, 8'h42, 8'hA1, 8'hE0, 8'h45, 8'hA3, 8'hA4,
    8'hA5, 8'hA6, 8'h4B, 8'hA7, 8'h4D, 8'h48, 8'h4F, 8'hA8,
    8'h50, 8'h43, 8'h54, 8'hA9, 8'hAA, 8'h58, 8'hE1, 8'hAB,
    8'hAC, 8'hE2, 8'hAD, 8'hAE, 8'h62, 8'hAF, 8'hB0, 8'hB1,
    8'h61, 8'hB2, 8'hB3, 8'hB4, 8'hE3, 8'h65, 8'hB6, 8'hB7,
    8'hB8, 8'hB9, 8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'h6F, 8'hBE,
    8'h70, 8'h63, 8'hBF, 8'h79, 8'hE4, 8'h78, 8'hE5, 8'hC0,
    8'hC1, 8'hE6, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7
  };

  localparam logic [StepW-1:0] CMD_LAST_STEP  = 3'd4;
  localparam logic [StepW-1:0] DATA_LAST_STEP = 3'd3;

  // byte ready for the bus, built from one request
  typedef struct packed {
    logic             is_cmd;
    logic [ByteW-1:0] byte_val;
  } req_t;

endpackage

@@ rtl/cln_if.sv @@
`timescale 1ns / 1ps

interface cln_in_if
  import cln_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [FuncW-1:0] func;
  logic [ByteW-1:0] value;
  logic [RowW-1:0]  row;

  modport source (output valid, output func, output value, output row, input ready);
  modport sink   (input valid, input func, input value, input row, output ready);
endinterface

interface cln_out_if
  import cln_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [NibW-1:0]  nibble;
  logic             enable;
  logic             reg_select;
  logic [HoldW-1:0] hold;
  logic             last;

  modport source (output valid, output nibble, output enable, output reg_select,
                  output hold, output last, input ready);
  modport sink   (input valid, input nibble, input enable, input reg_select,
                  input hold, input last, output ready);
endinterface

@@ rtl/cln_seq.sv @@
`timescale 1ns / 1ps

module cln_seq
  import cln_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  req_t              req_i,
  output logic              req_take_o,
  input  logic [PulseW-1:0] pulse_hold_i,
  input  logic [HoldW-1:0]  cmd_lead_i,
  cln_out_if.source         res_o
);

  logic             active_q, active_d;
  logic             cmd_q;
  logic [ByteW-1:0] byte_q;
  logic [NibW-1:0]  bus_snap_q;
  logic [NibW-1:0]  bus_now_q;
  logic [StepW-1:0] step_q, step_d;

  logic             out_valid_q;
  logic [NibW-1:0]  out_nib_q, out_nib_d;
  logic             out_en_q, out_en_d;
  logic             out_rs_q, out_rs_d;
  logic [HoldW-1:0] out_hold_q, out_hold_d;
  logic             out_last_q, out_last_d;

  logic             out_free;
  logic             emit;
  logic             emit_last;
  logic             load;
  logic [NibW-1:0]  hi_nib;
  logic [NibW-1:0]  lo_nib;
  logic [HoldW-1:0] pulse_ext;

  assign out_free  = !out_valid_q || res_o.ready;
  assign emit      = active_q && out_free;
  assign hi_nib    = byte_q[ByteW-1 -: NibW];
  assign lo_nib    = byte_q[NibW-1:0];
  assign pulse_ext = {{(HoldW-PulseW){1'b0}}, pulse_hold_i};
  assign emit_last = emit && (step_q == (cmd_q ? CMD_LAST_STEP : DATA_LAST_STEP));
  assign load      = req_valid_i && (!active_q || emit_last);
  assign req_take_o = load;

  // pin state for the current step
  always_comb begin
    out_nib_d  = lo_nib;
    out_en_d   = 1'b0;
    out_rs_d   = 1'b0;
    out_hold_d = pulse_ext;
    out_last_d = 1'b0;
    if (cmd_q) begin
      case (step_q)
        3'd0: begin
          out_nib_d  = bus_snap_q;
          out_hold_d = cmd_lead_i;
        end
        3'd1: begin
          out_nib_d = hi_nib;
          out_en_d  = 1'b1;
        end
        3'd2: out_en_d = 1'b0;
        3'd3: out_en_d = 1'b1;
        default: begin
          out_hold_d = '0;
          out_last_d = 1'b1;
        end
      endcase
    end else begin
      case (step_q)
        3'd0: begin
          out_nib_d = hi_nib;
          out_en_d  = 1'b1;
          out_rs_d  = 1'b1;
        end
        3'd1: out_en_d = 1'b0;
        3'd2: begin
          out_en_d = 1'b1;
          out_rs_d = 1'b1;
        end
        default: begin
          out_nib_d  = '0;
          out_hold_d = '0;
          out_last_d = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    active_d = active_q;
    step_d   = step_q;
    if (emit) begin
      step_d = step_q + 3'd1;
    end
    if (emit_last) begin
      active_d = 1'b0;
    end
    if (load) begin
      active_d = 1'b1;
      step_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      step_q      <= '0;
      bus_now_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      active_q <= active_d;
      step_q   <= step_d;
      if (load) begin
        bus_now_q <= req_i.is_cmd ? req_i.byte_val[NibW-1:0] : '0;
      end
      if (out_free) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cmd_q      <= req_i.is_cmd;
      byte_q     <= req_i.byte_val;
      bus_snap_q <= bus_now_q;
    end
    if (emit) begin
      out_nib_q  <= out_nib_d;
      out_en_q   <= out_en_d;
      out_rs_q   <= out_rs_d;
      out_hold_q <= out_hold_d;
      out_last_q <= out_last_d;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.nibble     = out_nib_q;
  assign res_o.enable     = out_en_q;
  assign res_o.reg_select = out_rs_q;
  assign res_o.hold       = out_hold_q;
  assign res_o.last       = out_last_q;

  a_data_step_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q && !cmd_q |-> step_q <= DATA_LAST_STEP)
    else $error("data sequence ran past its last step");

  a_cmd_step_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q && cmd_q |-> step_q <= CMD_LAST_STEP)
    else $error("command sequence ran past its last step");

  a_load_when_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> !active_q || emit_last)
    else $error("new byte loaded over an unfinished sequence");

  a_emit_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && !emit_last && !load |=> active_q && step_q == $past(step_q) + 3'd1)
    else $error("sequence step did not advance after a pin state");

endmodule

@@ rtl/char_lcd_nibble_writer.sv @@
`timescale 1ns / 1ps

// a request passes the input register, the sequencer's step and byte registers and its result register on its way out
// commands and cursor moves go out as five pin states, data and text as four, through
//   the single result channel that carries one pin state a cycle while res_o is ready
// the next request waits in the input register while the current one is emitted
// reset: pulse_hold 10, command_lead_hold 24000, bus level 0, no item in flight
module char_lcd_nibble_writer
  import cln_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  cln_in_if.sink             req_i,
  cln_out_if.source          res_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [HoldW-1:0]   cfg_data_i
);

  // configuration registers
  logic [PulseW-1:0] pulse_hold_q;
  logic [HoldW-1:0]  cmd_lead_q;

  // input register: one request, already turned into its bus byte
  logic             in_valid_q;
  req_t             in_req_q;
  req_t             in_req_d;
  logic             in_take;
  logic             in_accept;
  func_e            func;
  logic [ByteW-1:0] text_byte;
  logic [ByteW-1:0] cursor_byte;

  assign func = func_e'(req_i.func);

  // text at code 192 and above goes through the cyrillic glyph table
  assign text_byte = (req_i.value >= TEXT_REMAP_BASE)
                   ? CYR_ROM[req_i.value[5:0]] : req_i.value;

  // ddram address: row offset plus column, wrapping at 8 bits, set-address bit on top
  assign cursor_byte = (ROW_BASE[req_i.row] + req_i.value) | CURSOR_SET_BIT;

  always_comb begin
    in_req_d.is_cmd   = 1'b0;
    in_req_d.byte_val = req_i.value;
    unique case (func)
      FUNC_CMD:    in_req_d.is_cmd = 1'b1;
      FUNC_DATA:   in_req_d.byte_val = req_i.value;
      FUNC_TEXT:   in_req_d.byte_val = text_byte;
      FUNC_CURSOR: begin
        in_req_d.is_cmd   = 1'b1;
        in_req_d.byte_val = cursor_byte;
      end
      default:     in_req_d.byte_val = req_i.value;
    endcase
  end

  // the input register frees as soon as the sequencer takes its item
  assign req_i.ready = !in_valid_q || in_take;
  assign in_accept   = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      pulse_hold_q <= PULSE_HOLD_RST;
      cmd_lead_q   <= CMD_LEAD_RST;
    end else begin
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (in_take) begin
        in_valid_q <= 1'b0;
      end
      // unknown indexes are dropped
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_PULSE_HOLD: pulse_hold_q <= cfg_data_i[PulseW-1:0];
          CFG_CMD_LEAD:   cmd_lead_q   <= cfg_data_i;
          default:        ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_req_q <= in_req_d;
    end
  end

  // pin-state sequencer with its own result register
  cln_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (in_valid_q),
    .req_i        (in_req_q),
    .req_take_o   (in_take),
    .pulse_hold_i (pulse_hold_q),
    .cmd_lead_i   (cmd_lead_q),
    .res_o        (res_o)
  );

  a_take_needs_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |-> in_valid_q)
    else $error("sequencer took from an empty input register");

  a_item_kept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !in_take |=> in_valid_q && $stable(in_req_q))
    else $error("waiting item lost or changed in the input register");

  a_accept_fills : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_valid_q)
    else $error("accepted item did not reach the input register");

endmodule
